/* hw/rtl/cluster_quorum_tracker_defines.svh */
// Assertion helpers used by the datapath.
// Each one samples on clk and stays quiet while rst_n is low.
`ifndef CLUSTER_QUORUM_TRACKER_DEFINES_SVH
`define CLUSTER_QUORUM_TRACKER_DEFINES_SVH

// Same-cycle implication.
`define CQT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CQT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/cqt_pkg.sv */
package cqt_pkg;

    // Default table depth
    localparam int MAX_MEMBERS_DEF = 32;

    // Field widths
    localparam int ID_W    = 32;
    localparam int VOTE_W  = 16;
    localparam int SUM_W   = 24;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_SET_MEMBER = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET_UP     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RECOMPUTE  = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STAT_TABLE_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_VOTES   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_PRESENT = 1'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } cqt_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // latch the request, clear scan state
        logic scan;    // walk the member table
        logic commit;  // apply the update and raise the result strobe
    } cqt_cmd_t;

endpackage

/* hw/rtl/cqt_ctrl.sv */
module cqt_ctrl
    import cqt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     scan_done,
    output logic     busy,
    output cqt_cmd_t cmd
);

    cqt_state_t state_reg;
    cqt_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd    = '0;
        busy   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/cqt_datapath.sv */
`include "cluster_quorum_tracker_defines.svh"

module cqt_datapath
    import cqt_pkg::*;
#(
    parameter int MAX_MEMBERS = MAX_MEMBERS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cqt_cmd_t              cmd,
    output logic                  scan_done,
    input  logic [REQ_W-1:0]      req_type,
    input  logic [ID_W-1:0]       node_id,
    input  logic [VOTE_W-1:0]     member_votes,
    input  logic [VOTE_W-1:0]     member_expected,
    input  logic                  member_up,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output logic [STAT_W-1:0]     status,
    output logic [SUM_W-1:0]      expected_total,
    output logic [SUM_W-1:0]      quorum_votes,
    output logic [SUM_W-1:0]      present_total,
    output logic                  has_quorum
);

    localparam int IDX_W = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int CNT_W = $clog2(MAX_MEMBERS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MEMBERS);

    // Member table
    logic [ID_W-1:0]   id_mem    [MAX_MEMBERS];
    logic [VOTE_W-1:0] votes_mem [MAX_MEMBERS];
    logic [VOTE_W-1:0] exp_mem   [MAX_MEMBERS];
    logic              up_mem    [MAX_MEMBERS];

    // Configuration
    logic [VOTE_W-1:0] disk_votes_reg;
    logic              disk_present_reg;

    // Latched request
    logic [REQ_W-1:0]  req_reg;
    logic [ID_W-1:0]   id_reg;
    logic [VOTE_W-1:0] votes_reg;
    logic [VOTE_W-1:0] exp_reg;
    logic              up_reg;

    // Table read port
    logic [ID_W-1:0]   rd_id_reg;
    logic [VOTE_W-1:0] rd_votes_reg;
    logic [VOTE_W-1:0] rd_exp_reg;
    logic              rd_up_reg;
    logic [IDX_W-1:0]  rd_slot_reg;

    // Control and persistent state
    logic [CNT_W-1:0]  count_reg,    count_next;
    logic [CNT_W-1:0]  addr_reg,     addr_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              hit_reg,      hit_next;
    logic [IDX_W-1:0]  slot_reg,     slot_next;
    logic [SUM_W-1:0]  all_reg,      all_next;
    logic [SUM_W-1:0]  upsum_reg,    upsum_next;
    logic [VOTE_W-1:0] big_reg,      big_next;
    logic [SUM_W-1:0]  hw_reg,       hw_next;
    logic [SUM_W-1:0]  quorum_reg,   quorum_next;
    logic [SUM_W-1:0]  present_reg,  present_next;
    logic [STAT_W-1:0] status_reg,   status_next;
    logic              done_reg,     done_next;

    logic              rd_en;
    logic              is_lookup;
    logic              id_match;
    logic [SUM_W-1:0]  disk_add;
    logic [SUM_W-1:0]  all_disk;
    logic [SUM_W-1:0]  up_disk;
    logic [SUM_W-1:0]  hw_cand;
    logic [SUM_W:0]    quorum_sum;
    logic [IDX_W-1:0]  wr_slot;
    logic              wr_id_en;
    logic              wr_fields_en;
    logic              wr_up_en;

    assign rd_en     = cmd.scan && (addr_reg < count_reg);
    assign scan_done = (addr_reg == count_reg) && !rd_valid_reg;
    assign is_lookup = (req_reg == REQ_SET_MEMBER) || (req_reg == REQ_SET_UP);
    assign id_match  = rd_valid_reg && (rd_id_reg == id_reg);

    // Final vote sums with the quorum disk folded in
    assign disk_add = disk_present_reg ? {{(SUM_W-VOTE_W){1'b0}}, disk_votes_reg} : '0;
    assign all_disk = all_reg + disk_add;
    assign up_disk  = upsum_reg + disk_add;

    always_comb
    begin
        hw_cand = hw_reg;
        if ({{(SUM_W-VOTE_W){1'b0}}, big_reg} > hw_cand)
        begin
            hw_cand = {{(SUM_W-VOTE_W){1'b0}}, big_reg};
        end
        if (all_disk > hw_cand)
        begin
            hw_cand = all_disk;
        end
    end

    assign quorum_sum = {1'b0, hw_cand} + (SUM_W+1)'(2);

    // Scan: issue one read a cycle, evaluate each entry from the read registers
    always_comb
    begin
        addr_next     = addr_reg;
        rd_valid_next = rd_en;
        hit_next      = hit_reg;
        slot_next     = slot_reg;
        all_next      = all_reg;
        upsum_next    = upsum_reg;
        big_next      = big_reg;
        if (cmd.load)
        begin
            addr_next  = '0;
            hit_next   = 1'b0;
            slot_next  = '0;
            all_next   = '0;
            upsum_next = '0;
            big_next   = '0;
        end
        else
        begin
            if (rd_en)
            begin
                addr_next = addr_reg + CNT_W'(1);
            end
            if (rd_valid_reg)
            begin
                all_next = all_reg + {{(SUM_W-VOTE_W){1'b0}}, rd_votes_reg};
                if (rd_up_reg)
                begin
                    upsum_next = upsum_reg + {{(SUM_W-VOTE_W){1'b0}}, rd_votes_reg};
                end
                if (rd_exp_reg > big_reg)
                begin
                    big_next = rd_exp_reg;
                end
            end
            if (is_lookup && id_match && !hit_reg)
            begin
                hit_next  = 1'b1;
                slot_next = rd_slot_reg;
            end
        end
    end

    // Commit: apply the request to the table and the vote totals
    always_comb
    begin
        count_next   = count_reg;
        hw_next      = hw_reg;
        quorum_next  = quorum_reg;
        present_next = present_reg;
        status_next  = status_reg;
        wr_slot      = slot_reg;
        wr_id_en     = 1'b0;
        wr_fields_en = 1'b0;
        wr_up_en     = 1'b0;
        done_next    = cmd.commit;
        if (cmd.commit)
        begin
            status_next = STAT_OK;
            case (req_reg)
                REQ_SET_MEMBER:
                begin
                    if (hit_reg)
                    begin
                        wr_fields_en = 1'b1;
                        wr_up_en     = 1'b1;
                    end
                    else if (count_reg < CNT_MAX)
                    begin
                        wr_slot      = count_reg[IDX_W-1:0];
                        wr_id_en     = 1'b1;
                        wr_fields_en = 1'b1;
                        wr_up_en     = 1'b1;
                        count_next   = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        status_next = STAT_TABLE_FULL;
                    end
                end
                REQ_SET_UP:
                begin
                    if (hit_reg)
                    begin
                        wr_up_en = 1'b1;
                    end
                    else
                    begin
                        status_next = STAT_NOT_FOUND;
                    end
                end
                REQ_RECOMPUTE:
                begin
                    hw_next      = hw_cand;
                    quorum_next  = quorum_sum[SUM_W:1];
                    present_next = up_disk;
                end
                default:
                begin
                    status_next = STAT_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_votes_reg   <= '0;
            disk_present_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DISK_VOTES:
                begin
                    disk_votes_reg <= cfg_data;
                end
                CFG_DISK_PRESENT:
                begin
                    disk_present_reg <= cfg_data[0];
                end
                default:
                begin
                    disk_votes_reg <= disk_votes_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            addr_reg     <= '0;
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
            slot_reg     <= '0;
            all_reg      <= '0;
            upsum_reg    <= '0;
            big_reg      <= '0;
            hw_reg       <= '0;
            quorum_reg   <= '0;
            present_reg  <= '0;
            status_reg   <= STAT_OK;
            done_reg     <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            addr_reg     <= addr_next;
            rd_valid_reg <= rd_valid_next;
            hit_reg      <= hit_next;
            slot_reg     <= slot_next;
            all_reg      <= all_next;
            upsum_reg    <= upsum_next;
            big_reg      <= big_next;
            hw_reg       <= hw_next;
            quorum_reg   <= quorum_next;
            present_reg  <= present_next;
            status_reg   <= status_next;
            done_reg     <= done_next;
        end
    end

    // Request latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= req_type;
            id_reg    <= node_id;
            votes_reg <= member_votes;
            exp_reg   <= member_expected;
            up_reg    <= member_up;
        end
    end

    // Table write port
    always_ff @(posedge clk)
    begin
        if (wr_id_en)
        begin
            id_mem[wr_slot] <= id_reg;
        end
        if (wr_fields_en)
        begin
            votes_mem[wr_slot] <= votes_reg;
            exp_mem[wr_slot]   <= exp_reg;
        end
        if (wr_up_en)
        begin
            up_mem[wr_slot] <= up_reg;
        end
    end

    // Table read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_id_reg    <= id_mem[addr_reg[IDX_W-1:0]];
            rd_votes_reg <= votes_mem[addr_reg[IDX_W-1:0]];
            rd_exp_reg   <= exp_mem[addr_reg[IDX_W-1:0]];
            rd_up_reg    <= up_mem[addr_reg[IDX_W-1:0]];
            rd_slot_reg  <= addr_reg[IDX_W-1:0];
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign expected_total = hw_reg;
    assign quorum_votes   = quorum_reg;
    assign present_total  = present_reg;
    assign has_quorum     = (present_reg >= quorum_reg);

    `CQT_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_MAX, "member count above table depth")
    `CQT_ASSERT_NEXT(a_hw_monotonic, 1'b1, hw_reg >= $past(hw_reg), "expected total decreased")
    `CQT_ASSERT_NEXT(a_done_single, done_reg, !done_reg, "result strobe held over two cycles")

endmodule

/* hw/rtl/cluster_quorum_tracker.sv */
// Channel   | Signals                                                  | Handshake
// ----------+----------------------------------------------------------+----------------------
// request   | req_type node_id member_votes member_expected member_up | start & !busy
// result    | status expected_total quorum_votes present_total         | done, one cycle
//           | has_quorum                                               |
// config    | cfg_index cfg_data                                       | cfg_write, no wait
//
// A request runs from acceptance through the table scan and the commit to the done strobe:
// the single read port delivers one entry a cycle and the last entry folds in from the read
// registers, so the table scan sets the length of a request.
// busy drops in the cycle that carries done, so the next request can be taken there.
// rst_n clears the member count and the vote totals; the table needs no clearing pass.
// Results cannot be stalled: sample them in the done cycle.
module cluster_quorum_tracker
    import cqt_pkg::*;
#(
    parameter int MAX_MEMBERS = MAX_MEMBERS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Request
    input  logic                  start,
    output logic                  busy,
    input  logic [REQ_W-1:0]      req_type,
    input  logic [ID_W-1:0]       node_id,
    input  logic [VOTE_W-1:0]     member_votes,
    input  logic [VOTE_W-1:0]     member_expected,
    input  logic                  member_up,

    // Result
    output logic                  done,
    output logic [STAT_W-1:0]     status,
    output logic [SUM_W-1:0]      expected_total,
    output logic [SUM_W-1:0]      quorum_votes,
    output logic [SUM_W-1:0]      present_total,
    output logic                  has_quorum,

    // Configuration
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Commands from the sequencer and scan completion back
    cqt_cmd_t cmd;
    logic     scan_done;

    // Sequence each request: latch, scan the table, commit
    cqt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .scan_done (scan_done),
        .busy      (busy),
        .cmd       (cmd)
    );

    // Hold the member table, the vote totals and the result registers
    cqt_datapath #(
        .MAX_MEMBERS (MAX_MEMBERS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .scan_done       (scan_done),
        .req_type        (req_type),
        .node_id         (node_id),
        .member_votes    (member_votes),
        .member_expected (member_expected),
        .member_up       (member_up),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .done            (done),
        .status          (status),
        .expected_total  (expected_total),
        .quorum_votes    (quorum_votes),
        .present_total   (present_total),
        .has_quorum      (has_quorum)
    );

endmodule

/* tb/cluster_quorum_tracker_tb.sv */
module cluster_quorum_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cqt_pkg::*;

    localparam int ROSTER_DEPTH = MAX_MEMBERS_DEF;
    localparam int ID_POOL_SIZE = 40;
    // The block answers code 3 like a no-op; the package leaves it unnamed.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [ID_W-1:0]   id;
        logic [VOTE_W-1:0] votes;
        logic [VOTE_W-1:0] expected;
        logic              up;
    } member_request_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SUM_W-1:0]  expected_total;
        logic [SUM_W-1:0]  quorum_votes;
        logic [SUM_W-1:0]  present_total;
        logic              has_quorum;
    } vote_outcome_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [REQ_W-1:0]      req_type;
    logic [ID_W-1:0]       node_id;
    logic [VOTE_W-1:0]     member_votes;
    logic [VOTE_W-1:0]     member_expected;
    logic                  member_up;
    logic                  done;
    logic [STAT_W-1:0]     status;
    logic [SUM_W-1:0]      expected_total;
    logic [SUM_W-1:0]      quorum_votes;
    logic [SUM_W-1:0]      present_total;
    logic                  has_quorum;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cluster_quorum_tracker u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .node_id         (node_id),
        .member_votes    (member_votes),
        .member_expected (member_expected),
        .member_up       (member_up),
        .done            (done),
        .status          (status),
        .expected_total  (expected_total),
        .quorum_votes    (quorum_votes),
        .present_total   (present_total),
        .has_quorum      (has_quorum),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the member roster, the disk setup and the last
    // recompute figures. Only entries below roster_count are ever read.
    // ------------------------------------------------------------------
    logic [ID_W-1:0]   roster_id       [ROSTER_DEPTH];
    logic [VOTE_W-1:0] roster_votes    [ROSTER_DEPTH];
    logic [VOTE_W-1:0] roster_expected [ROSTER_DEPTH];
    logic              roster_up       [ROSTER_DEPTH];
    int unsigned       roster_count;
    logic [SUM_W-1:0]  hw_expected;
    logic [SUM_W-1:0]  need_votes;
    logic [SUM_W-1:0]  up_votes;
    logic [VOTE_W-1:0] disk_weight;
    logic              disk_on;

    // Outcomes of accepted requests, oldest first.
    vote_outcome_t     outcome_q[$];

    logic [ID_W-1:0]   id_pool [ID_POOL_SIZE];
    int                burst_left;

    int errors;
    int sent;
    int checked;
    int recomputes;
    int reg_writes;
    int full_seen;
    int missing_seen;
    int no_quorum_seen;

    // 12 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs; the slowest legal run is far shorter.
    initial
    begin
        #5_000_000;
        $display("[cluster_quorum_tracker] ERROR");
        $finish;
    end

    // Apply one request to the shadow roster and return the answer the block
    // must give. Updates of an existing member never hit the table-full case.
    function automatic vote_outcome_t tally_request(member_request_t rq);
        int            slot;
        int unsigned   all_sum;
        int unsigned   up_sum;
        int unsigned   biggest;
        int unsigned   hw;
        vote_outcome_t res;
        res.status = STAT_OK;
        slot = -1;
        for (int i = 0; i < roster_count && slot < 0; i++)
        begin
            if (roster_id[i] == rq.id)
                slot = i;
        end
        case (rq.kind)
            REQ_SET_MEMBER:
            begin
                if (slot < 0)
                begin
                    if (roster_count >= ROSTER_DEPTH)
                        res.status = STAT_TABLE_FULL;
                    else
                    begin
                        slot = roster_count;
                        roster_count++;
                        roster_id[slot] = rq.id;
                    end
                end
                if (slot >= 0)
                begin
                    roster_votes[slot]    = rq.votes;
                    roster_expected[slot] = rq.expected;
                    roster_up[slot]       = rq.up;
                end
            end
            REQ_SET_UP:
            begin
                if (slot < 0)
                    res.status = STAT_NOT_FOUND;
                else
                    roster_up[slot] = rq.up;
            end
            REQ_RECOMPUTE:
            begin
                all_sum = 0;
                up_sum  = 0;
                biggest = 0;
                for (int i = 0; i < roster_count; i++)
                begin
                    all_sum += roster_votes[i];
                    if (roster_expected[i] > biggest)
                        biggest = roster_expected[i];
                    if (roster_up[i])
                        up_sum += roster_votes[i];
                end
                if (disk_on)
                begin
                    all_sum += disk_weight;
                    up_sum  += disk_weight;
                end
                // The expected total is a high-water mark: it only rises.
                hw = hw_expected;
                if (biggest > hw)
                    hw = biggest;
                if (all_sum > hw)
                    hw = all_sum;
                hw_expected = hw[SUM_W-1:0];
                hw = (hw_expected + 2) / 2;
                need_votes = hw[SUM_W-1:0];
                up_votes   = up_sum[SUM_W-1:0];
            end
            default: ;
        endcase
        res.expected_total = hw_expected;
        res.quorum_votes   = need_votes;
        res.present_total  = up_votes;
        res.has_quorum     = (up_votes >= need_votes);
        return res;
    endfunction

    function automatic member_request_t make_request(logic [REQ_W-1:0] kind,
                                                     logic [ID_W-1:0] id,
                                                     logic [VOTE_W-1:0] votes,
                                                     logic [VOTE_W-1:0] expected,
                                                     logic up);
        member_request_t rq;
        rq.kind     = kind;
        rq.id       = id;
        rq.votes    = votes;
        rq.expected = expected;
        rq.up       = up;
        return rq;
    endfunction

    task automatic check_field(string what, logic [SUM_W-1:0] want, logic [SUM_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: done marks exactly one cycle, so sample every edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        vote_outcome_t want;
        if (rst_n && done === 1'b1)
        begin
            if (outcome_q.size() == 0)
            begin
                $display("%0t ns: result with no request pending, status %0d",
                         $time, status);
                errors++;
            end
            else
            begin
                want = outcome_q.pop_front();
                checked++;
                check_field("status",         want.status,         status);
                check_field("expected_total", want.expected_total, expected_total);
                check_field("quorum_votes",   want.quorum_votes,   quorum_votes);
                check_field("present_total",  want.present_total,  present_total);
                check_field("has_quorum",     want.has_quorum,     has_quorum);
                if (want.status == STAT_TABLE_FULL)
                    full_seen++;
                if (want.status == STAT_NOT_FOUND)
                    missing_seen++;
                if (!want.has_quorum)
                    no_quorum_seen++;
            end
        end
    end

    // Send one request after an idle gap of the given length. Leave start
    // high on return: a back-to-back request then just swaps the fields at
    // the next falling edge, and a later gap lowers it.
    task automatic send_request(member_request_t rq, int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start           <= 1'b1;
        req_type        <= rq.kind;
        node_id         <= rq.id;
        member_votes    <= rq.votes;
        member_expected <= rq.expected;
        member_up       <= rq.up;
        // busy read here is the value just before the edge.
        do
            @(posedge clk);
        while (busy !== 1'b0);
        outcome_q.push_back(tally_request(rq));
        sent++;
        if (rq.kind == REQ_RECOMPUTE)
            recomputes++;
    endtask

    // Drop start and hold until every pending answer has come back.
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_DISK_VOTES)
            disk_weight = val;
        else
            disk_on = val[0];
        reg_writes++;
    endtask

    // Reconfigure the quorum disk; the block must be idle first.
    task automatic set_disk(logic [VOTE_W-1:0] votes, logic present);
        settle();
        write_reg(CFG_DISK_VOTES, votes);
        write_reg(CFG_DISK_PRESENT, {{(CFG_DATA_W-1){1'b0}}, present});
    endtask

    // Sender gap: mostly drawn at random, with occasional runs of back-to-back
    // requests.
    function automatic int draw_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            burst_left = $urandom_range(5, 20);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    // Mostly modest vote counts so quorum flips both ways, plus the extremes.
    function automatic logic [VOTE_W-1:0] draw_votes();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return VOTE_W'($urandom_range(0, 255));
        if (pick < 8)
            return VOTE_W'($urandom_range(0, 65535));
        if (pick == 8)
            return '0;
        return '1;
    endfunction

    // Pool ids fill the 32-entry roster and then run into table full;
    // fresh random ids mostly miss on set-up and add new members.
    function automatic member_request_t draw_request();
        member_request_t rq;
        int              pick;
        pick = $urandom_range(0, 99);
        rq.id       = id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
        rq.votes    = draw_votes();
        rq.expected = draw_votes();
        rq.up       = ($urandom_range(0, 4) != 0);
        if (pick < 40)
            rq.kind = REQ_SET_MEMBER;
        else if (pick < 45)
        begin
            rq.kind = REQ_SET_MEMBER;
            rq.id   = $urandom;
        end
        else if (pick < 65)
            rq.kind = REQ_SET_UP;
        else if (pick < 72)
        begin
            rq.kind = REQ_SET_UP;
            rq.id   = $urandom;
        end
        else if (pick < 92)
            rq.kind = REQ_RECOMPUTE;
        else
            rq.kind = REQ_UNUSED;
        return rq;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Before any recompute every figure is zero, so quorum holds; an empty
    // roster answers set-up with not found; recompute of nothing needs 1 vote.
    task automatic test_idle_answers();
        send_request(make_request(REQ_UNUSED, '0, '0, '0, 1'b0), draw_gap());
        send_request(make_request(REQ_SET_UP, 32'h1234_5678, '0, '0, 1'b1), draw_gap());
        send_request(make_request(REQ_RECOMPUTE, '1, '1, '1, 1'b1), draw_gap());
    endtask

    // Insert and update members at the field extremes, toggle the up flag,
    // miss on an unknown id and drop below quorum.
    task automatic test_member_updates();
        send_request(make_request(REQ_SET_MEMBER, '0, '0, '0, 1'b0), draw_gap());
        send_request(make_request(REQ_SET_MEMBER, '1, '1, '1, 1'b1), draw_gap());
        send_request(make_request(REQ_SET_MEMBER, 32'h5A5A_A5A5, 16'h00FF, 16'hFF00, 1'b1),
                     draw_gap());
        send_request(make_request(REQ_RECOMPUTE, '0, '0, '0, 1'b0), draw_gap());
        send_request(make_request(REQ_SET_MEMBER, '0, 16'd1, 16'd2, 1'b1), draw_gap());
        send_request(make_request(REQ_SET_UP, '1, '0, '0, 1'b0), draw_gap());
        send_request(make_request(REQ_RECOMPUTE, '0, '0, '0, 1'b0), draw_gap());
        send_request(make_request(REQ_SET_UP, '1, '0, '0, 1'b1), draw_gap());
        send_request(make_request(REQ_SET_UP, 32'hFFFF_FFFE, '1, '1, 1'b1), draw_gap());
        send_request(make_request(REQ_RECOMPUTE, '0, '0, '0, 1'b0), draw_gap());
        send_request(make_request(REQ_UNUSED, '1, '1, '1, 1'b1), draw_gap());
    endtask

    // Quorum disk at full weight, present with zero weight, and absent.
    task automatic test_quorum_disk();
        set_disk('1, 1'b1);
        send_request(make_request(REQ_RECOMPUTE, '0, '0, '0, 1'b0), draw_gap());
        set_disk('0, 1'b1);
        send_request(make_request(REQ_RECOMPUTE, '0, '0, '0, 1'b0), draw_gap());
        set_disk(16'd1234, 1'b0);
        send_request(make_request(REQ_RECOMPUTE, '0, '0, '0, 1'b0), draw_gap());
    endtask

    // One phase of random traffic under a fixed disk setup. Now and then
    // hold off until the block has answered everything.
    task automatic test_random_traffic(logic [VOTE_W-1:0] votes, logic present, int count);
        set_disk(votes, present);
        for (int n = 0; n < count; n++)
        begin
            send_request(draw_request(), draw_gap());
            if ($urandom_range(0, 39) == 0)
                settle();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        req_type        = REQ_SET_MEMBER;
        node_id         = '0;
        member_votes    = '0;
        member_expected = '0;
        member_up       = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = CFG_DISK_VOTES;
        cfg_data        = '0;

        roster_count = 0;
        hw_expected  = '0;
        need_votes   = '0;
        up_votes     = '0;
        disk_weight  = '0;
        disk_on      = 1'b0;
        burst_left   = 0;
        errors       = 0;
        sent         = 0;
        checked      = 0;
        recomputes   = 0;
        reg_writes   = 0;
        full_seen    = 0;
        missing_seen = 0;
        no_quorum_seen = 0;
        for (int i = 0; i < ID_POOL_SIZE; i++)
            id_pool[i] = $urandom;

        // Hold reset, then release it away from the rising edge.
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_answers();
        test_member_updates();
        test_quorum_disk();
        test_random_traffic('0, 1'b0, 125);
        test_random_traffic('1, 1'b1, 125);
        test_random_traffic(VOTE_W'($urandom_range(1, 65534)), 1'b1, 125);
        test_random_traffic(VOTE_W'($urandom_range(0, 65535)), 1'b0, 125);

        // Drain, then give the block a full scan's worth of quiet cycles.
        settle();
        repeat (ROSTER_DEPTH + 8) @(posedge clk);

        $display("Covered %0d requests (%0d recomputes), %0d answers checked, %0d register writes",
                 sent, recomputes, checked, reg_writes);
        $display("Saw %0d table-full, %0d not-found and %0d no-quorum answers; roster holds %0d",
                 full_seen, missing_seen, no_quorum_seen, roster_count);
        if (errors == 0)
            $display("[cluster_quorum_tracker] OK");
        else
            $display("[cluster_quorum_tracker] ERROR");
        $finish;
    end

endmodule
